/* rtl/core/stt_pkg.sv */
// Shared types and constants of the sparse trace table.
// Depends on nothing; imported by stt_dpath, stt_ctrl, the top level and the bench.
package stt_pkg;

	localparam logic [1:0] OP_DECAY   = 2'd0;
	localparam logic [1:0] OP_CLEAR   = 2'd1;
	localparam logic [1:0] OP_SET     = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic REG_DECAY_FACTOR    = 1'b0;
	localparam logic REG_START_THRESHOLD = 1'b1;

	localparam logic [15:0] DECAY_RESET  = 16'd58982;
	localparam logic [15:0] THRESH_RESET = 16'd328;
	localparam logic [15:0] THRESH_MAX   = 16'hFFFF;
	localparam logic [31:0] GROW_MUL     = 32'd18022;
	localparam int          GROW_SHIFT   = 14;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_DISP, ST_R_RAL, ST_R_ZERO, ST_L_CHK, ST_C_POS,
		ST_S_FULL, ST_S_RAISE, ST_W_RAL, ST_W_RTS, ST_W_EVAL, ST_W_DEC,
		ST_W_NEXT, ST_D_RD, ST_D_WR, ST_FIN
	} stt_state_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic cur_feat;
		logic cur_al;
		logic ts_rd_feat;
		logic ts_rd_al;
		logic pos_rd_feat;
		logic al_rd_slot;
		logic al_rd_last;
		logic slot_last;
		logic slot_pos;
		logic slot_dec;
		logic prod_ld;
		logic ts_wr_val;
		logic ts_wr_dec;
		logic ts_wr_zero_al;
		logic ts_wr_zero_cur;
		logic append;
		logic move;
		logic len_dec;
		logic thr_start;
		logic thr_grow;
		logic trace_val;
		logic out_load;
	} stt_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       len_zero;
		logic       len_one;
		logic       len_full;
		logic       feat_ok;
		logic       ts_nz;
		logic       is_clear;
		logic       thr_max;
		logic       cull_hit;
		logic       dec_drop;
		logic       slot_zero;
		logic       clr_done;
		logic       out_free;
	} stt_status_t;

endpackage

/* rtl/core/stt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module stt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/core/stt_dpath.sv */
// Datapath of the sparse trace table: trace store, active list, position map,
// arithmetic and result register. Depends on stt_pkg and stt_ram.
module stt_dpath #(
	parameter int FEATURES   = 4096,
	parameter int MAX_ACTIVE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stt_pkg::stt_cmd_t  cmd,
	output stt_pkg::stt_status_t status,
	input  logic [1:0]         opcode,
	input  logic [11:0]        feature_index,
	input  logic [15:0]        trace_value,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [8:0]         active_count,
	output logic [15:0]        trace_out,
	output logic [15:0]        threshold_out
);
	import stt_pkg::*;

	localparam int AW = $clog2(FEATURES);
	localparam int SW = $clog2(MAX_ACTIVE);
	localparam int LW = $clog2(MAX_ACTIVE + 1);

	logic [1:0]    op_q;
	logic [AW-1:0] feat_q, cur_q, clr_q;
	logic          feat_ok_q;
	logic [15:0]   val_q, thr_q, dfac_q, sthr_q, trace_q;
	logic [LW-1:0] len_q, len_m1;
	logic [SW-1:0] slot_q;
	logic [31:0]   prod_q, grow;
	logic [15:0]   dec_t, grow_t;
	logic          dec_drop;

	logic          ts_we, ts_re;
	logic [AW-1:0] ts_waddr, ts_raddr;
	logic [15:0]   ts_wdata, ts_rdata;
	logic          al_we, al_re;
	logic [SW-1:0] al_waddr, al_raddr;
	logic [AW-1:0] al_wdata, al_rdata;
	logic          pos_we;
	logic [AW-1:0] pos_waddr;
	logic [SW-1:0] pos_wdata, pos_rdata;

	assign len_m1   = len_q - 1'b1;
	assign dec_t    = prod_q[31:16];
	assign dec_drop = (dec_t < thr_q) || (dec_t == 16'd0);
	assign grow     = (32'(thr_q) * GROW_MUL) >> GROW_SHIFT;

	always_comb begin
		if (grow > 32'(THRESH_MAX)) begin
			grow_t = THRESH_MAX;
		end else if (grow <= 32'(thr_q)) begin
			grow_t = thr_q + 16'd1;
		end else begin
			grow_t = grow[15:0];
		end
	end

	// memory port steering
	always_comb begin
		ts_we    = cmd.clr_step | cmd.ts_wr_val | cmd.ts_wr_dec | cmd.ts_wr_zero_al
			| cmd.ts_wr_zero_cur;
		ts_waddr = cur_q;
		ts_wdata = 16'd0;
		priority if (cmd.clr_step) begin
			ts_waddr = clr_q;
		end else if (cmd.ts_wr_val) begin
			ts_waddr = feat_q;
			ts_wdata = val_q;
		end else if (cmd.ts_wr_dec) begin
			ts_wdata = dec_drop ? 16'd0 : dec_t;
		end else if (cmd.ts_wr_zero_al) begin
			ts_waddr = al_rdata;
		end else begin
			ts_waddr = cur_q;
		end
		ts_re    = cmd.ts_rd_feat | cmd.ts_rd_al;
		ts_raddr = cmd.ts_rd_al ? al_rdata : feat_q;

		al_we    = cmd.append | cmd.move;
		al_waddr = cmd.append ? len_q[SW-1:0] : slot_q;
		al_wdata = cmd.append ? feat_q : al_rdata;
		al_re    = cmd.al_rd_slot | cmd.al_rd_last;
		al_raddr = cmd.al_rd_last ? len_m1[SW-1:0] : slot_q;

		pos_we    = cmd.append | cmd.move;
		pos_waddr = cmd.append ? feat_q : al_rdata;
		pos_wdata = cmd.append ? len_q[SW-1:0] : slot_q;
	end

	stt_ram #(.WIDTH(16), .DEPTH(FEATURES)) u_trace (
		.clk(clk), .we(ts_we), .waddr(ts_waddr), .wdata(ts_wdata),
		.re(ts_re), .raddr(ts_raddr), .rdata(ts_rdata)
	);

	stt_ram #(.WIDTH(AW), .DEPTH(MAX_ACTIVE)) u_list (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.re(al_re), .raddr(al_raddr), .rdata(al_rdata)
	);

	stt_ram #(.WIDTH(SW), .DEPTH(FEATURES)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.re(cmd.pos_rd_feat), .raddr(feat_q), .rdata(pos_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			len_q     <= '0;
			thr_q     <= THRESH_RESET;
			dfac_q    <= DECAY_RESET;
			sthr_q    <= THRESH_RESET;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.append) begin
				len_q <= len_q + 1'b1;
			end else if (cmd.len_dec) begin
				len_q <= len_m1;
			end
			if (cmd.thr_start) begin
				thr_q <= sthr_q;
			end else if (cmd.thr_grow) begin
				thr_q <= grow_t;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DECAY_FACTOR:    dfac_q <= cfg_data;
					REG_START_THRESHOLD: sthr_q <= cfg_data;
				endcase
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= opcode;
			feat_q    <= AW'(feature_index);
			feat_ok_q <= 32'(feature_index) < FEATURES;
			val_q     <= trace_value;
			trace_q   <= 16'd0;
		end
		if (cmd.trace_val) begin
			trace_q <= val_q;
		end
		if (cmd.cur_feat) begin
			cur_q <= feat_q;
		end else if (cmd.cur_al) begin
			cur_q <= al_rdata;
		end
		priority if (cmd.slot_last) begin
			slot_q <= len_m1[SW-1:0];
		end else if (cmd.slot_pos) begin
			slot_q <= pos_rdata;
		end else if (cmd.slot_dec) begin
			slot_q <= slot_q - 1'b1;
		end
		if (cmd.prod_ld) begin
			prod_q <= 32'(ts_rdata) * 32'(dfac_q);
		end
		if (cmd.out_load) begin
			active_count  <= 9'(len_q);
			trace_out     <= trace_q;
			threshold_out <= thr_q;
		end
	end

	always_comb begin
		status.op        = op_q;
		status.len_zero  = len_q == '0;
		status.len_one   = len_q == LW'(1);
		status.len_full  = len_q >= LW'(MAX_ACTIVE);
		status.feat_ok   = feat_ok_q;
		status.ts_nz     = ts_rdata != 16'd0;
		status.is_clear  = (op_q == OP_CLEAR) || ((op_q == OP_SET) && (val_q == 16'd0));
		status.thr_max   = thr_q == THRESH_MAX;
		status.cull_hit  = ts_rdata < thr_q;
		status.dec_drop  = dec_drop;
		status.slot_zero = slot_q == '0;
		status.clr_done  = clr_q == AW'(FEATURES - 1);
		status.out_free  = !out_valid || out_ready;
	end
endmodule

/* rtl/core/stt_ctrl.sv */
// Controller of the sparse trace table: sequences each operation over the
// datapath. Depends on stt_pkg.
module stt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  stt_pkg::stt_status_t status,
	output stt_pkg::stt_cmd_t    cmd
);
	import stt_pkg::*;

	stt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DISP;
				end
			end
			ST_DISP: begin
				cmd.cur_feat = 1'b1;
				if (status.op == OP_DECAY) begin
					if (status.len_zero) begin
						state_d = ST_FIN;
					end else begin
						cmd.slot_last = 1'b1;
						state_d       = ST_W_RAL;
					end
				end else if (status.op == OP_RESTART) begin
					if (status.len_zero) begin
						cmd.thr_start = 1'b1;
						state_d       = ST_FIN;
					end else begin
						state_d = ST_R_RAL;
					end
				end else if (!status.feat_ok) begin
					state_d = ST_FIN;
				end else begin
					cmd.ts_rd_feat = 1'b1;
					state_d        = ST_L_CHK;
				end
			end
			ST_R_RAL: begin
				cmd.al_rd_last = 1'b1;
				state_d        = ST_R_ZERO;
			end
			ST_R_ZERO: begin
				cmd.ts_wr_zero_al = 1'b1;
				cmd.len_dec       = 1'b1;
				if (status.len_one) begin
					cmd.thr_start = 1'b1;
					state_d       = ST_FIN;
				end else begin
					state_d = ST_R_RAL;
				end
			end
			ST_L_CHK: begin
				if (status.is_clear) begin
					if (status.ts_nz) begin
						cmd.pos_rd_feat = 1'b1;
						state_d         = ST_C_POS;
					end else begin
						state_d = ST_FIN;
					end
				end else if (status.ts_nz) begin
					cmd.ts_wr_val = 1'b1;
					cmd.trace_val = 1'b1;
					state_d       = ST_FIN;
				end else begin
					state_d = ST_S_FULL;
				end
			end
			ST_C_POS: begin
				cmd.slot_pos = 1'b1;
				state_d      = ST_D_RD;
			end
			ST_S_FULL: begin
				if (status.len_full) begin
					state_d = status.thr_max ? ST_FIN : ST_S_RAISE;
				end else begin
					cmd.append    = 1'b1;
					cmd.ts_wr_val = 1'b1;
					cmd.trace_val = 1'b1;
					state_d       = ST_FIN;
				end
			end
			ST_S_RAISE: begin
				cmd.thr_grow  = 1'b1;
				cmd.slot_last = 1'b1;
				state_d       = ST_W_RAL;
			end
			ST_W_RAL: begin
				cmd.al_rd_slot = 1'b1;
				state_d        = ST_W_RTS;
			end
			ST_W_RTS: begin
				cmd.cur_al   = 1'b1;
				cmd.ts_rd_al = 1'b1;
				state_d      = ST_W_EVAL;
			end
			ST_W_EVAL: begin
				if (status.op == OP_DECAY) begin
					cmd.prod_ld = 1'b1;
					state_d     = ST_W_DEC;
				end else begin
					state_d = status.cull_hit ? ST_D_RD : ST_W_NEXT;
				end
			end
			ST_W_DEC: begin
				cmd.ts_wr_dec = 1'b1;
				state_d       = status.dec_drop ? ST_D_RD : ST_W_NEXT;
			end
			ST_W_NEXT: begin
				if (status.slot_zero) begin
					state_d = (status.op == OP_DECAY) ? ST_FIN : ST_S_FULL;
				end else begin
					cmd.slot_dec = 1'b1;
					state_d      = ST_W_RAL;
				end
			end
			ST_D_RD: begin
				cmd.al_rd_last = 1'b1;
				state_d        = ST_D_WR;
			end
			ST_D_WR: begin
				cmd.move           = 1'b1;
				cmd.ts_wr_zero_cur = 1'b1;
				cmd.len_dec        = 1'b1;
				state_d            = status.is_clear ? ST_FIN : ST_W_NEXT;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

/* rtl/core/sparse_trace_table.sv */
// Top level of the sparse trace table: controller plus datapath.
// Depends on stt_pkg, stt_ctrl and stt_dpath (which holds the stt_ram stores).
//
// Holds one unsigned Q1.15 trace per feature and a dense list of the active
// features with a feature-to-slot map; a removal moves the last list entry
// into the freed slot. After reset the trace store is swept to zero, one entry
// a cycle, with in_ready low; configuration writes are taken throughout. Items
// are taken one at a time; the next item is accepted while the previous result
// still waits on the output register. The time per item is set by the walk
// over the active list, one entry at a time through the simple dual-port stores.
// Every item passes accept, dispatch and result load; the result load waits
// while the output register still holds a result that has not been taken. In
// between: nothing for a clear or set out of range; a check for a set on a
// listed feature or a clear of an unlisted one; check and append for an append;
// check, slot lookup, last-entry read and move for a clear of a listed feature;
// restart reads and zeroes each active entry; decay reads, scales, writes back
// and steps each entry, plus a last-entry read and move per dropped one; a set
// on a full list raises the threshold, then checks each entry, culling those below.
module sparse_trace_table #(
	parameter int FEATURES   = 4096,
	parameter int MAX_ACTIVE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [11:0] feature_index,
	input  logic [15:0] trace_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  active_count,
	output logic [15:0] trace_out,
	output logic [15:0] threshold_out,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import stt_pkg::*;

	stt_cmd_t    cmd;
	stt_status_t status;

	// sequence each operation
	stt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	// stores, arithmetic and result register
	stt_dpath #(.FEATURES(FEATURES), .MAX_ACTIVE(MAX_ACTIVE)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.opcode(opcode), .feature_index(feature_index), .trace_value(trace_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.active_count(active_count), .trace_out(trace_out),
		.threshold_out(threshold_out)
	);

	// list never grows past its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(active_count) <= MAX_ACTIVE)
		else $error("active_count beyond capacity");

	// a nonzero trace result means the feature is listed
	a_trace_listed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trace_out != 16'd0 |-> active_count != 9'd0)
		else $error("nonzero trace with empty list");

	// one item at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back accept");
endmodule

/* bench/tb.sv */
// Self-checking bench for the sparse trace table: a directed table, then random phases.
// Depends on stt_pkg and the sparse_trace_table RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stt_pkg::*;

	localparam int FEAT = 4096;
	localparam int CAP  = 256;
	localparam int PHASE_ITEMS = 326;

	typedef struct packed {
		logic [8:0]  cnt;
		logic [15:0] trace;
		logic [15:0] thr;
	} table_res_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] feat;
		logic [15:0] val;
		logic        typed;
		table_res_t  res;
	} table_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = OP_DECAY;
	logic [11:0] feature_index = '0;
	logic [15:0] trace_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [8:0]  active_count;
	logic [15:0] trace_out;
	logic [15:0] threshold_out;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_DECAY_FACTOR;
	logic [15:0] cfg_data = '0;

	sparse_trace_table u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the table state
	logic [15:0] trc_mem [FEAT];
	logic [11:0] slot_feat [CAP];
	logic [7:0]  feat_slot [FEAT];
	int unsigned slots_used;
	int unsigned min_trace;
	int unsigned decay_mul;
	int unsigned restart_thr;

	table_res_t  pending_res [$];
	bit          failed = 1'b0;

	// Typed expectation for the item currently offered (directed rows only)
	logic        row_typed = 1'b0;
	table_res_t  row_res;

	int unsigned burst_left = 0;

	function automatic void evict(int unsigned slot);
		int unsigned moved;
		trc_mem[slot_feat[slot]] = '0;
		slots_used--;
		moved = slot_feat[slots_used];
		slot_feat[slot] = moved[11:0];
		feat_slot[moved] = slot[7:0];
	endfunction

	function automatic void cull(int unsigned lim);
		int unsigned s;
		s = slots_used;
		while (s > 0) begin
			s--;
			if (trc_mem[slot_feat[s]] < lim)
				evict(s);
		end
	endfunction

	function automatic void decay_sweep();
		int unsigned s;
		int unsigned t;
		s = slots_used;
		while (s > 0) begin
			s--;
			t = 32'((64'(trc_mem[slot_feat[s]]) * decay_mul) >> 16);
			trc_mem[slot_feat[s]] = t[15:0];
			if (t < min_trace || t == 0)
				evict(s);
		end
	endfunction

	function automatic void grow_threshold();
		int unsigned n;
		n = (min_trace * GROW_MUL) >> GROW_SHIFT;
		if (n <= min_trace)
			n = min_trace + 1;
		if (n > THRESH_MAX)
			n = THRESH_MAX;
		min_trace = n;
	endfunction

	function automatic void store_trace(int unsigned f, logic [15:0] v);
		if (trc_mem[f] != 0) begin
			trc_mem[f] = v;
			return;
		end
		while (slots_used >= CAP && min_trace < THRESH_MAX) begin
			grow_threshold();
			cull(min_trace);
		end
		if (slots_used >= CAP)
			return;
		trc_mem[f] = v;
		slot_feat[slots_used] = f[11:0];
		feat_slot[f] = slots_used[7:0];
		slots_used++;
	endfunction

	function automatic table_res_t apply_op(logic [1:0] op, logic [11:0] f, logic [15:0] v);
		table_res_t r;
		r.trace = '0;
		case (op)
			OP_DECAY: begin
				decay_sweep();
			end
			OP_RESTART: begin
				while (slots_used > 0)
					evict(slots_used - 1);
				min_trace = restart_thr;
			end
			default: begin
				// a set of zero behaves as a clear
				if (op == OP_SET && v != 0)
					store_trace(f, v);
				else if (trc_mem[f] != 0)
					evict(feat_slot[f]);
				r.trace = trc_mem[f];
			end
		endcase
		r.cnt = slots_used[8:0];
		r.thr = min_trace[15:0];
		return r;
	endfunction

	// Predict on every accepted item; directed rows may carry their own result
	always @(posedge clk) begin
		table_res_t r;
		if (arst_n && in_valid && in_ready) begin
			r = apply_op(opcode, feature_index, trace_value);
			pending_res.insert(pending_res.size(), row_typed ? row_res : r);
		end
	end

	// Compare every result with the oldest pending one
	always @(posedge clk) begin
		table_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_res.size() == 0) begin
				$error("unexpected result: count %0d trace %0d threshold %0d",
					active_count, trace_out, threshold_out);
				failed = 1'b1;
			end else begin
				e = pending_res.pop_front();
				if (active_count !== e.cnt) begin
					$error("active_count: expected %0d, got %0d", e.cnt, active_count);
					failed = 1'b1;
				end
				if (trace_out !== e.trace) begin
					$error("trace_out: expected %0d, got %0d", e.trace, trace_out);
					failed = 1'b1;
				end
				if (threshold_out !== e.thr) begin
					$error("threshold_out: expected %0d, got %0d", e.thr, threshold_out);
					failed = 1'b1;
				end
			end
		end
	end

	// Receiver stalls: the pattern switches among four modes picked at random
	always @(posedge clk) begin
		int unsigned cyc;
		int unsigned mode;
		cyc = cyc + 1;
		if (cyc % 300 == 0)
			mode = $urandom_range(0, 3);
		case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cyc % 7 < 3);
		endcase
	end

	// Offer one item: bursts of random length, random gaps between them
	task automatic offer(logic [1:0] op, logic [11:0] f, logic [15:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		opcode <= op;
		feature_index <= f;
		trace_value <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drain, then write both registers while the block is idle
	task automatic set_regs(logic [15:0] dec, logic [15:0] thr);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_res.size() == 0);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_DECAY_FACTOR;
		cfg_data <= dec;
		@(posedge clk);
		cfg_index <= REG_START_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		decay_mul = dec;
		restart_thr = thr;
	endtask

	task automatic random_item();
		int unsigned pick;
		logic [1:0]  op;
		logic [11:0] f;
		logic [15:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			op = OP_SET;
		else if (pick < 84)
			op = OP_CLEAR;
		else if (pick < 97)
			op = OP_DECAY;
		else
			op = OP_RESTART;
		// a narrow window keeps features coming back; the full range exercises every bit
		f = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, FEAT - 1))
			: 12'($urandom_range(0, 399));
		case ($urandom_range(0, 7))
			0: v = 16'hFFFF;
			1: v = '0;
			2, 3: v = 16'($urandom_range(1, 1000));
			default: v = 16'($urandom_range(0, 65535));
		endcase
		row_typed <= 1'b0;
		offer(op, f, v);
	endtask

	// Directed rows: edges of the fields, every op, the special cases
	table_row_t directed [] = '{
		'{OP_DECAY,   12'd0,    16'd0,     1'b1, '{9'd0, 16'd0,     16'd328}},
		'{OP_SET,     12'd0,    16'hFFFF,  1'b1, '{9'd1, 16'hFFFF,  16'd328}},
		'{OP_SET,     12'd4095, 16'd1,     1'b1, '{9'd2, 16'd1,     16'd328}},
		'{OP_SET,     12'd0,    16'd0,     1'b1, '{9'd1, 16'd0,     16'd328}},
		'{OP_CLEAR,   12'd4095, 16'hFFFF,  1'b1, '{9'd0, 16'd0,     16'd328}},
		'{OP_CLEAR,   12'd7,    16'd0,     1'b1, '{9'd0, 16'd0,     16'd328}},
		'{OP_SET,     12'd7,    16'd1000,  1'b1, '{9'd1, 16'd1000,  16'd328}},
		'{OP_SET,     12'd7,    16'd2000,  1'b1, '{9'd1, 16'd2000,  16'd328}},
		'{OP_SET,     12'd8,    16'd400,   1'b0, '0},
		'{OP_SET,     12'd2730, 16'd330,   1'b0, '0},
		'{OP_DECAY,   12'd0,    16'd0,     1'b0, '0},
		'{OP_DECAY,   12'd0,    16'd0,     1'b0, '0},
		'{OP_SET,     12'd1365, 16'h5555,  1'b0, '0},
		'{OP_CLEAR,   12'd8,    16'd0,     1'b0, '0},
		'{OP_RESTART, 12'hFFF,  16'hFFFF,  1'b1, '{9'd0, 16'd0,     16'd328}}
	};

	// Per phase: decay factor and restart threshold, extremes among them
	logic [15:0] phase_dec [5] = '{16'd58982, 16'd65535, 16'd0,     16'd65535, 16'd32768};
	logic [15:0] phase_thr [5] = '{16'd328,   16'd1,     16'd0,     16'd65535, 16'd1000};

	initial begin
		for (int i = 0; i < FEAT; i++) begin
			trc_mem[i] = '0;
			feat_slot[i] = '0;
		end
		for (int i = 0; i < CAP; i++)
			slot_feat[i] = '0;
		slots_used = 0;
		min_trace = THRESH_RESET;
		decay_mul = DECAY_RESET;
		restart_thr = THRESH_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table at reset settings
		foreach (directed[i]) begin
			row_typed <= directed[i].typed;
			row_res <= directed[i].res;
			offer(directed[i].op, directed[i].feat, directed[i].val);
		end
		row_typed <= 1'b0;

		// Random phases; each starts with a restart so the new threshold loads
		for (int p = 0; p < 5; p++) begin
			set_regs(phase_dec[p], phase_thr[p]);
			offer(OP_RESTART, 12'($urandom_range(0, FEAT - 1)), 16'($urandom_range(0, 65535)));
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end

		in_valid <= 1'b0;
		wait (pending_res.size() == 0);
		repeat (50) @(posedge clk);
		if (!failed)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#40ms;
		$display("FAIL");
		$finish;
	end
endmodule
